/* hdl/swps_pkg.sv */
package swps_pkg;

    // Longest window and longest trace that the datapath is built for.
    localparam int MAX_WINDOW = 16;
    localparam int MAX_SLICES = 64;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 12;
    localparam int START_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int WLEN_W   = 5;
    localparam int TAP_W    = $clog2(MAX_WINDOW);
    localparam int MIN_WINDOW = 2;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // Configuration register indices.
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAT_LIMIT  = 1'd1;

    // Control handed to every cell of the delay chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

/* hdl/sliding_window_peak_search_core.sv */
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  s_tdata[7:0] sample, s_tlast last sample of trace
// m_       out        m_tvalid/m_tready  m_tdata peak_sum, start_slice, sat_count, first_sat_pos
// cfg_     in         cfg_we             cfg_addr register index, cfg_wdata value
//
// One sample is taken per clock cycle while s_tready is high; the result of a trace appears on
// m_ in the cycle after the transfer of its last sample, held in a single output register.
// The sample delay line is a chain of cells that shift once per transfer of a sample that still
// counts; the window sum, comparison and saturation count are updated in that same cycle.
// Reset (aresetn low, synchronous) clears the trace state and loads the register defaults.
// A result that is not taken holds the input off until the result has been transferred.
module sliding_window_peak_search_core
    import swps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] sample
    input  logic                  s_tlast,   // last_sample
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [11:0] peak_sum, [17:12] start_slice,
                                             // [24:18] sat_count, [31:25] first_sat_pos
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [WLEN_W-1:0]   window_len_reg, window_len_next;
    logic [SAMPLE_W-1:0] sat_limit_reg,  sat_limit_next;

    // Per-trace state.
    logic [SUM_W-1:0]   running_sum_reg, running_sum_next;
    logic [SUM_W-1:0]   best_sum_reg,    best_sum_next;
    logic [START_W-1:0] best_start_reg,  best_start_next;
    logic [COUNT_W-1:0] slice_index_reg, slice_index_next;
    logic [COUNT_W-1:0] sat_count_reg,   sat_count_next;
    logic [COUNT_W-1:0] first_sat_reg,   first_sat_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg,  m_data_next;

    logic                s_xfer;
    logic                active;
    logic [SAMPLE_W-1:0] sample;
    logic [WLEN_W-1:0]   win;
    logic [SAMPLE_W-1:0] oldest;
    logic [SUM_W-1:0]    sum_upd;
    logic [SUM_W-1:0]    best_upd;
    logic [START_W-1:0]  start_upd;
    logic [COUNT_W-1:0]  count_upd;
    logic [COUNT_W-1:0]  first_upd;
    logic [COUNT_W-1:0]  start_full;
    logic                in_fill;
    logic                is_sat;
    cell_ctrl_t          cell_ctrl;
    logic [SAMPLE_W-1:0] tap [MAX_WINDOW];

    // The input is taken whenever the output register is free or is being emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_W-1:0];
    assign active   = (slice_index_reg < COUNT_W'(MAX_SLICES));

    // The delay chain shifts only for samples that still count, and is wiped
    // at the end of every trace.
    assign cell_ctrl.shift = s_xfer && active;
    assign cell_ctrl.clear = s_xfer && s_tlast;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            swps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .din     (sample),
                .dout    (tap[g])
            );
        end else begin : g_body
            swps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .din     (tap[g-1]),
                .dout    (tap[g])
            );
        end
    end

    // Window length is clamped into the range the chain supports.
    always_comb begin
        win = window_len_reg;
        if (window_len_reg < WLEN_W'(MIN_WINDOW)) begin
            win = WLEN_W'(MIN_WINDOW);
        end else if (window_len_reg > WLEN_W'(MAX_WINDOW)) begin
            win = WLEN_W'(MAX_WINDOW);
        end
    end

    assign oldest  = tap[TAP_W'(win - WLEN_W'(1))];
    assign in_fill = (slice_index_reg < COUNT_W'(win));
    assign is_sat  = (sample >= sat_limit_reg);

    // Start of the window that ends at the current sample.
    assign start_full = slice_index_reg - COUNT_W'(win) + COUNT_W'(1);

    always_comb begin
        sum_upd = running_sum_reg + SUM_W'(sample);
        if (!in_fill) begin
            sum_upd = sum_upd - SUM_W'(oldest);
        end

        best_upd  = best_sum_reg;
        start_upd = best_start_reg;
        if (in_fill) begin
            // While the window is still filling, the partial sum is the best.
            best_upd  = sum_upd;
            start_upd = '0;
        end else if (sum_upd > best_sum_reg) begin
            best_upd  = sum_upd;
            start_upd = start_full[START_W-1:0];
        end

        count_upd = sat_count_reg;
        first_upd = first_sat_reg;
        if (is_sat) begin
            if (sat_count_reg == '0) begin
                first_upd = slice_index_reg + COUNT_W'(1);
            end
            count_upd = sat_count_reg + COUNT_W'(1);
        end
    end

    // Trace state: updated by counting samples, cleared after the last one.
    always_comb begin
        running_sum_next = running_sum_reg;
        best_sum_next    = best_sum_reg;
        best_start_next  = best_start_reg;
        slice_index_next = slice_index_reg;
        sat_count_next   = sat_count_reg;
        first_sat_next   = first_sat_reg;
        if (s_xfer) begin
            if (s_tlast) begin
                running_sum_next = '0;
                best_sum_next    = '0;
                best_start_next  = '0;
                slice_index_next = '0;
                sat_count_next   = '0;
                first_sat_next   = '0;
            end else if (active) begin
                running_sum_next = sum_upd;
                best_sum_next    = best_upd;
                best_start_next  = start_upd;
                slice_index_next = slice_index_reg + COUNT_W'(1);
                sat_count_next   = count_upd;
                first_sat_next   = first_upd;
            end
        end
    end

    // Output register: loaded with the final figures of a trace.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_xfer && s_tlast) begin
            m_valid_next = 1'b1;
            if (active) begin
                m_data_next = {first_upd, count_upd, start_upd, best_upd};
            end else begin
                m_data_next = {first_sat_reg, sat_count_reg, best_start_reg, best_sum_reg};
            end
        end
    end

    // Configuration writes.
    always_comb begin
        window_len_next = window_len_reg;
        sat_limit_next  = sat_limit_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_WINDOW_LEN: window_len_next = cfg_wdata[WLEN_W-1:0];
                REG_SAT_LIMIT:  sat_limit_next  = cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg  <= WLEN_W'(4);
            sat_limit_reg   <= SAMPLE_W'(254);
            running_sum_reg <= '0;
            best_sum_reg    <= '0;
            best_start_reg  <= '0;
            slice_index_reg <= '0;
            sat_count_reg   <= '0;
            first_sat_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            window_len_reg  <= window_len_next;
            sat_limit_reg   <= sat_limit_next;
            running_sum_reg <= running_sum_next;
            best_sum_reg    <= best_sum_next;
            best_start_reg  <= best_start_next;
            slice_index_reg <= slice_index_next;
            sat_count_reg   <= sat_count_next;
            first_sat_reg   <= first_sat_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by m_valid_reg.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hdl/swps_cell.sv */
module swps_cell
    import swps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] dout
);

    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;

    // A clear at the end of a trace takes priority over the shift.
    always_comb begin
        sample_next = sample_reg;
        if (ctrl.clear) begin
            sample_next = '0;
        end else if (ctrl.shift) begin
            sample_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign dout = sample_reg;

endmodule

/* hdl/swps_checker.sv */
module swps_checker
    import swps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    logic [COUNT_W-1:0] chk_count;
    logic [COUNT_W-1:0] chk_first;

    assign chk_count = m_tdata[24:18];
    assign chk_first = m_tdata[31:25];

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A saturation count and its first position are zero together.
    a_sat_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((chk_count == '0) == (chk_first == '0)))
        else $error("saturation count and first position disagree");

    // Saturated samples lie between the first one and the end of the trace.
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, chk_count} + {1'b0, chk_first} <= (COUNT_W+1)'(MAX_SLICES + 1)))
        else $error("saturation count exceeds the trace length");

    // A result appears only after the last sample of a trace.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a last sample");

endmodule

bind sliding_window_peak_search_core swps_checker u_swps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
